FILE: rtl/sbkl_pkg.sv
// Package for the static search-tree key lookup unit.
// Holds tree geometry constants, payload and control types, and address helpers.
// No dependencies; every other file in rtl/ depends on it.
package sbkl_pkg;

	// Tree geometry.
	localparam int NODE_KEYS = 16;
	localparam int TREE_LEVELS = 3;

	// Fixed field widths.
	localparam int KEY_HIGH_W = 32;
	localparam int KEY_MID_W = 64;
	localparam int KEY_LOW_W = 64;
	localparam int COUNT_W = 31;

	// Number of nodes on one level of the tree.
	function automatic int level_nodes(input int lvl);
		int nodes;
		nodes = 1;
		for (int l = 0; l < TREE_LEVELS; l++) begin
			if (l < lvl) begin
				nodes = nodes * NODE_KEYS;
			end
		end
		return nodes;
	endfunction

	// First store address of one level; levels are packed root first.
	function automatic int level_base(input int lvl);
		int base;
		int nodes;
		base = 0;
		nodes = 1;
		for (int l = 0; l < TREE_LEVELS; l++) begin
			if (l < lvl) begin
				base = base + nodes * NODE_KEYS;
				nodes = nodes * NODE_KEYS;
			end
		end
		return base;
	endfunction

	localparam int STORE_DEPTH = level_base(TREE_LEVELS);
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int NODE_W = $clog2(level_nodes(TREE_LEVELS - 1));
	localparam int SLOT_W = $clog2(NODE_KEYS);
	localparam int IDX_W = $clog2(NODE_KEYS + 1);
	localparam int LVL_W = $clog2(TREE_LEVELS);

	// Action codes of an input word.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic [KEY_HIGH_W-1:0] high;
		logic [KEY_MID_W-1:0] middle;
		logic [KEY_LOW_W-1:0] low;
	} key_t;

	typedef struct packed {
		key_t key;
		logic [COUNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic action;
		logic [1:0] level;
		logic [7:0] node_index;
		logic [3:0] slot;
		logic [KEY_HIGH_W-1:0] key_high;
		logic [KEY_MID_W-1:0] key_middle;
		logic [KEY_LOW_W-1:0] key_low;
		logic [COUNT_W-1:0] count_in;
	} req_word_t;

	typedef struct packed {
		logic found;
		logic [COUNT_W-1:0] count_out;
	} rsp_word_t;

	// Access request from the sequencer to the key store.
	typedef struct packed {
		logic we;
		logic re;
		logic [ADDR_W-1:0] addr;
		entry_t wentry;
	} store_req_t;

	// Outcome of comparing the searched key with one stored key.
	typedef struct packed {
		logic less;
		logic equal;
	} cmp_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

FILE: rtl/sbkl_if.sv
// Valid/ready channel interfaces for the lookup unit's request and response words.
// Depends on sbkl_pkg for the payload types.
interface sbkl_req_if;
	logic valid;
	logic ready;
	sbkl_pkg::req_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sbkl_rsp_if;
	logic valid;
	logic ready;
	sbkl_pkg::rsp_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/static_btree_key_lookup_unit.sv
// Top level of the static search-tree key lookup unit.
// Depends on sbkl_pkg, sbkl_if, sbkl_store, sbkl_cmp and sbkl_ctrl.
//
// Usage:
// - req carries one word per valid/ready handshake. A word with action 0 loads one
//   slot (key and count) of the three-level tree and gives no response;
//   out-of-range loads are dropped. A word with action 1 searches for its key.
// - rsp carries one word per search: found, and the stored count (0 if not found).
// - The user must load the whole tree, with all-ones sentinels in unused slots, before
//   searches; the block itself does not enforce this.
// - A search reads one slot per cycle from the single-port key store and compares it in
//   the shared 160-bit comparator. Each level starts with a read of its first slot, then
//   compares one slot as the next is read, and takes the descent on the deciding compare.
// - req.ready is high only while no search is in progress; loads go back to back, and
//   a search holds the input until its result has moved into the response register.
// - The response sits in an output register. A new word is taken while it waits, and
//   a search that finishes behind a stalled response waits until that one is taken.
// - arst_n clears the sequencer and the response valid; the store keeps its contents
//   undefined until loaded.
module static_btree_key_lookup_unit (
	input logic clk,
	input logic arst_n,
	sbkl_req_if.sink req,
	sbkl_rsp_if.source rsp
);
	import sbkl_pkg::*;

	store_req_t store_req;
	entry_t rd_entry;
	key_t search_key;
	cmp_res_t cmp_res;

	// Sequencer and response register.
	sbkl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.store(store_req),
		.rd_entry(rd_entry),
		.key(search_key),
		.cmp(cmp_res)
	);

	// Key and count memory.
	sbkl_store u_store (
		.clk(clk),
		.req(store_req),
		.rd_entry(rd_entry)
	);

	// Shared comparator between the searched key and the slot just read.
	sbkl_cmp u_cmp (
		.search_key(search_key),
		.stored_key(rd_entry.key),
		.res(cmp_res)
	);

endmodule

FILE: rtl/sbkl_store.sv
// Key and count store of the lookup unit: one single-port memory with registered read.
// Depends on sbkl_pkg.
module sbkl_store (
	input logic clk,
	input sbkl_pkg::store_req_t req,
	output sbkl_pkg::entry_t rd_entry
);
	import sbkl_pkg::*;

	entry_t mem [STORE_DEPTH];
	entry_t rd_entry_q;

	// One write or one read per cycle at the requested address.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wentry;
		end
		if (req.re) begin
			rd_entry_q <= mem[req.addr];
		end
	end

	assign rd_entry = rd_entry_q;

endmodule

FILE: rtl/sbkl_cmp.sv
// Shared 160-bit magnitude comparator of the lookup unit.
// Depends on sbkl_pkg.
module sbkl_cmp (
	input sbkl_pkg::key_t search_key,
	input sbkl_pkg::key_t stored_key,
	output sbkl_pkg::cmp_res_t res
);
	import sbkl_pkg::*;

	// The packed key orders high, middle, low, so a plain compare is lexicographic.
	always_comb begin
		res.less = search_key < stored_key;
		res.equal = search_key == stored_key;
	end

endmodule

FILE: rtl/sbkl_ctrl.sv
// Sequencer of the lookup unit: accepts words, loads slots, walks the tree one slot per
// cycle through the store and the shared comparator, and holds the response register.
// Depends on sbkl_pkg and sbkl_if.
module sbkl_ctrl (
	input logic clk,
	input logic arst_n,
	sbkl_req_if.sink req,
	sbkl_rsp_if.source rsp,
	output sbkl_pkg::store_req_t store,
	input sbkl_pkg::entry_t rd_entry,
	output sbkl_pkg::key_t key,
	input sbkl_pkg::cmp_res_t cmp
);
	import sbkl_pkg::*;

	state_t state_q, state_d;
	key_t key_q;
	logic [LVL_W-1:0] lvl_q;
	logic [NODE_W-1:0] node_q;
	logic [IDX_W-1:0] issue_q;
	logic [SLOT_W-1:0] pend_idx_q;
	logic pend_q;
	logic res_found_q;
	logic [COUNT_W-1:0] res_count_q;
	logic out_valid_q;
	logic out_found_q;
	logic [COUNT_W-1:0] out_count_q;

	logic accept;
	logic is_search;
	logic wr_ok;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic issue_ok;
	logic last_lvl;
	logic last_slot;
	logic scan_end;
	logic descend;
	logic out_free;
	logic [NODE_W-1:0] node_next;

	assign accept = req.valid && req.ready;
	assign is_search = req.data.action == ACT_SEARCH;

	// Write address and range check of a slot load.
	always_comb begin
		wr_ok = (int'(req.data.level) < TREE_LEVELS)
			&& (int'(req.data.node_index) < level_nodes(int'(req.data.level)))
			&& (int'(req.data.slot) < NODE_KEYS);
		wr_addr = ADDR_W'(level_base(int'(req.data.level)))
			+ ADDR_W'(req.data.node_index) * ADDR_W'(NODE_KEYS)
			+ ADDR_W'(req.data.slot);
	end

	// Read address of the slot issued this cycle.
	assign rd_addr = ADDR_W'(level_base(int'(lvl_q)))
		+ ADDR_W'(node_q) * ADDR_W'(NODE_KEYS)
		+ ADDR_W'(issue_q);
	assign issue_ok = int'(issue_q) < NODE_KEYS;

	// Scan decisions on the word that came back from the store.
	always_comb begin
		last_lvl = int'(lvl_q) == TREE_LEVELS - 1;
		last_slot = int'(pend_idx_q) == NODE_KEYS - 1;
		scan_end = pend_q && (cmp.equal || (cmp.less && last_lvl)
			|| (!cmp.less && !cmp.equal && last_slot));
		descend = pend_q && cmp.less && !cmp.equal && !last_lvl;
		node_next = node_q * NODE_W'(NODE_KEYS) + NODE_W'(pend_idx_q);
	end

	assign out_free = !out_valid_q || rsp.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_search) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs: handshake ready and store access.
	always_comb begin
		req.ready = 1'b0;
		store.we = 1'b0;
		store.re = 1'b0;
		store.addr = rd_addr;
		store.wentry.key.high = req.data.key_high;
		store.wentry.key.middle = req.data.key_middle;
		store.wentry.key.low = req.data.key_low;
		store.wentry.count = req.data.count_in;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				store.we = accept && !is_search && wr_ok;
				store.addr = wr_addr;
			end
			ST_SCAN: begin
				store.re = issue_ok;
			end
			ST_FIN: begin
				store.re = 1'b0;
			end
			default: begin
				store.re = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q <= '0;
			node_q <= '0;
			issue_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept && is_search) begin
				lvl_q <= '0;
				node_q <= '0;
				issue_q <= '0;
				pend_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				pend_q <= issue_ok && !descend && !scan_end;
				if (descend) begin
					lvl_q <= lvl_q + LVL_W'(1);
					node_q <= node_next;
					issue_q <= '0;
				end else if (issue_ok) begin
					issue_q <= issue_q + IDX_W'(1);
				end
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: searched key, slot in flight, result and response word.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && is_search) begin
			key_q.high <= req.data.key_high;
			key_q.middle <= req.data.key_middle;
			key_q.low <= req.data.key_low;
		end
		if (state_q == ST_SCAN) begin
			pend_idx_q <= issue_q[SLOT_W-1:0];
		end
		if (state_q == ST_SCAN && scan_end) begin
			res_found_q <= cmp.equal;
			res_count_q <= cmp.equal ? rd_entry.count : '0;
		end
		if (state_q == ST_FIN && out_free) begin
			out_found_q <= res_found_q;
			out_count_q <= res_count_q;
		end
	end

	assign key = key_q;
	assign rsp.valid = out_valid_q;
	assign rsp.data.found = out_found_q;
	assign rsp.data.count_out = out_count_q;

endmodule

FILE: dv/sbkl_lookup_checker.sv
// Checker for the static search-tree key lookup unit.
// Watches the request and response channels, keeps its own copy of the tree,
// predicts every lookup and compares the responses. Depends on sbkl_pkg and sbkl_if.
module sbkl_lookup_checker (
	input logic clk,
	input logic arst_n,
	sbkl_req_if req,
	sbkl_rsp_if rsp,
	output int errors,
	output int waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import sbkl_pkg::*;

	typedef logic [KEY_HIGH_W+KEY_MID_W+KEY_LOW_W-1:0] key_vec_t;

	// Shadow of the key store, flat and root first, as the block holds it.
	key_vec_t tree_key [STORE_DEPTH];
	logic [COUNT_W-1:0] tree_count [STORE_DEPTH];

	// Predicted responses of searches that have been accepted.
	rsp_word_t lookup_results [$];

	// Store one slot; slots outside the tree are dropped.
	function automatic void load_slot(input req_word_t w);
		int start;
		int span;
		int addr;
		start = 0;
		span = 1;
		for (int l = 0; l < w.level; l++) begin
			start += span * NODE_KEYS;
			span *= NODE_KEYS;
		end
		if (w.level >= TREE_LEVELS || w.node_index >= span || w.slot >= NODE_KEYS) begin
			return;
		end
		addr = start + w.node_index * NODE_KEYS + w.slot;
		tree_key[addr] = {w.key_high, w.key_middle, w.key_low};
		tree_count[addr] = w.count_in;
	endfunction

	// Walk the tree from the root: stop at the first key that is not smaller,
	// report a hit on an equal key, give up past the last slot or at a leaf,
	// otherwise descend to the child under the stopping slot.
	function automatic rsp_word_t lookup_key(input key_vec_t probe);
		rsp_word_t res;
		int start;
		int span;
		int node;
		int here;
		int pos;
		res = '0;
		start = 0;
		span = 1;
		node = 0;
		for (int l = 0; l < TREE_LEVELS; l++) begin
			here = start + node * NODE_KEYS;
			pos = 0;
			while (pos < NODE_KEYS && tree_key[here + pos] < probe) begin
				pos++;
			end
			if (pos == NODE_KEYS) begin
				return res;
			end
			if (tree_key[here + pos] == probe) begin
				res.found = 1'b1;
				res.count_out = tree_count[here + pos];
				return res;
			end
			start += span * NODE_KEYS;
			span *= NODE_KEYS;
			node = node * NODE_KEYS + pos;
		end
		return res;
	endfunction

	// Count a failure and describe the first few of them.
	task automatic flag_mismatch(input string what, input rsp_word_t want, input rsp_word_t got);
		errors++;
		if (errors <= 10) begin
			$display("%0t: %s: expected found=%0b count=%0d, got found=%0b count=%0d",
				$realtime, what, want.found, want.count_out, got.found, got.count_out);
		end
	endtask

	// Responses are matched before new requests are taken in, since a response
	// can never belong to a search accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		req_word_t w;
		if (!arst_n) begin
			lookup_results.delete();
			waiting = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (lookup_results.size() == 0) begin
					flag_mismatch("response word with no search waiting", '0, rsp.data);
				end else begin
					want = lookup_results.pop_front();
					if (rsp.data.found !== want.found || rsp.data.count_out !== want.count_out) begin
						flag_mismatch("lookup response differs", want, rsp.data);
					end
				end
			end
			if (req.valid && req.ready) begin
				w = req.data;
				if (w.action == ACT_WRITE) begin
					load_slot(w);
				end else begin
					lookup_results.push_back(lookup_key({w.key_high, w.key_middle, w.key_low}));
				end
			end
			waiting = lookup_results.size();
		end
	end

endmodule

FILE: dv/static_btree_key_lookup_unit_test.sv
// Top of the testbench for the static search-tree key lookup unit.
// Builds well-formed trees, searches them under varied idling and hands checking
// to sbkl_lookup_checker. Depends on sbkl_pkg, sbkl_if and the unit itself.
module static_btree_key_lookup_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sbkl_pkg::*;

	typedef logic [KEY_HIGH_W+KEY_MID_W+KEY_LOW_W-1:0] key_vec_t;

	// One planned slot of a tree under construction.
	typedef struct packed {
		logic [1:0] level;
		logic [7:0] node;
		logic [3:0] slot;
		key_vec_t key;
	} slot_fill_t;

	localparam key_vec_t KEY_SENTINEL = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam int PHASES = 7;
	localparam int PROBES_PER_PHASE = 120;
	localparam int TAIL_CYCLES = 64;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count;
	int open_lookups;
	int cycle_count = 0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int inc_shift = 12;

	// Current tree: every slot placed, every real key, and every slot a search may read.
	slot_fill_t layout [$];
	key_vec_t tree_keys [$];
	bit readable [TREE_LEVELS][NODE_KEYS * 256];

	sbkl_req_if req_ch ();
	sbkl_rsp_if rsp_ch ();

	static_btree_key_lookup_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	sbkl_lookup_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.errors(fail_count),
		.waiting(open_lookups)
	);

	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Response side: stall at random at the current rate.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic key_vec_t rand_key();
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return COUNT_MAX;
			end
			default: begin
				return COUNT_W'($urandom);
			end
		endcase
	endfunction

	function automatic req_word_t rand_word();
		req_word_t w;
		w.action = 1'($urandom_range(0, 1));
		w.level = 2'($urandom_range(0, 3));
		w.node_index = 8'($urandom_range(0, 255));
		w.slot = 4'($urandom_range(0, 15));
		{w.key_high, w.key_middle, w.key_low} = rand_key();
		w.count_in = pick_count();
		return w;
	endfunction

	// Next key in ascending order, with steps from one up to wide jumps.
	function automatic key_vec_t next_key(input key_vec_t prev);
		key_vec_t inc;
		logic [KEY_HIGH_W+KEY_MID_W+KEY_LOW_W:0] sum;
		case ($urandom_range(0, 3))
			0: begin
				inc = key_vec_t'($urandom_range(1, 3));
			end
			1: begin
				inc = key_vec_t'({$urandom, $urandom});
			end
			default: begin
				inc = rand_key() >> $urandom_range(inc_shift, 159);
			end
		endcase
		if (inc == '0) begin
			inc = key_vec_t'(1);
		end
		sum = {1'b0, prev} + {1'b0, inc};
		if (sum >= {1'b0, KEY_SENTINEL}) begin
			return prev + 1'b1;
		end
		return sum[KEY_HIGH_W+KEY_MID_W+KEY_LOW_W-1:0];
	endfunction

	// Children a node can lead to: one per key plus the sentinel slot, or one
	// per key when the node is full.
	function automatic int fanout(input int n);
		return (n < NODE_KEYS) ? n + 1 : NODE_KEYS;
	endfunction

	function automatic void place(input int level, input int node, input int slot, input key_vec_t key);
		slot_fill_t f;
		f.level = 2'(level);
		f.node = 8'(node);
		f.slot = 4'(slot);
		f.key = key;
		layout.push_back(f);
		readable[level][node * NODE_KEYS + slot] = 1'b1;
		if (key != KEY_SENTINEL) begin
			tree_keys.push_back(key);
		end
	endfunction

	// Lay out an ordered tree in key order: child subtree, then the key above it.
	// Every node that a search can reach is built, ending in a sentinel unless full.
	function automatic void plan_tree(input int root_n, input int mid_max, input int leaf_max,
			input int full_pct, input key_vec_t base);
		key_vec_t k;
		int mid_n;
		int leaf_n;
		int leaf_node;
		layout.delete();
		tree_keys.delete();
		readable = '{default: '0};
		k = base;
		for (int a = 0; a < fanout(root_n); a++) begin
			mid_n = $urandom_range(0, mid_max);
			for (int b = 0; b < fanout(mid_n); b++) begin
				leaf_n = ($urandom_range(0, 99) < full_pct) ? NODE_KEYS : $urandom_range(0, leaf_max);
				leaf_node = a * NODE_KEYS + b;
				for (int c = 0; c < leaf_n; c++) begin
					k = next_key(k);
					place(2, leaf_node, c, k);
				end
				if (leaf_n < NODE_KEYS) begin
					place(2, leaf_node, leaf_n, KEY_SENTINEL);
				end
				if (b < mid_n) begin
					k = next_key(k);
					place(1, a, b, k);
				end
			end
			if (mid_n < NODE_KEYS) begin
				place(1, a, mid_n, KEY_SENTINEL);
			end
			if (a < root_n) begin
				k = next_key(k);
				place(0, 0, a, k);
			end
		end
		if (root_n < NODE_KEYS) begin
			place(0, 0, root_n, KEY_SENTINEL);
		end
	endfunction

	// Offer one word, after a random idle, and hold it until it is taken.
	// Entered and left at a falling edge.
	task automatic send_word(input req_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic fill_slot(input int level, input int node, input int slot, input key_vec_t key,
			input logic [COUNT_W-1:0] count);
		req_word_t w;
		w = rand_word();
		w.action = ACT_WRITE;
		w.level = 2'(level);
		w.node_index = 8'(node);
		w.slot = 4'(slot);
		{w.key_high, w.key_middle, w.key_low} = key;
		w.count_in = count;
		send_word(w);
	endtask

	task automatic search_key(input key_vec_t key);
		req_word_t w;
		w = rand_word();
		w.action = ACT_SEARCH;
		{w.key_high, w.key_middle, w.key_low} = key;
		send_word(w);
	endtask

	// A write that no search can see: out of range, or into a slot off every path.
	task automatic send_stray_write();
		req_word_t w;
		w = rand_word();
		w.action = ACT_WRITE;
		if (w.level < TREE_LEVELS && readable[w.level][w.node_index * NODE_KEYS + w.slot]) begin
			w.level = 2'd3;
		end
		send_word(w);
	endtask

	// Load the planned tree in shuffled order with stray writes mixed in.
	task automatic load_tree();
		slot_fill_t tmp;
		int j;
		for (int i = layout.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = layout[i];
			layout[i] = layout[j];
			layout[j] = tmp;
		end
		foreach (layout[i]) begin
			if ($urandom_range(0, 99) < 10) begin
				send_stray_write();
			end
			fill_slot(layout[i].level, layout[i].node, layout[i].slot, layout[i].key, pick_count());
		end
	endtask

	// Search keys: stored ones most often, then neighbors, the sentinel, zero and noise.
	function automatic key_vec_t pick_probe();
		int sel;
		key_vec_t k;
		sel = $urandom_range(0, 99);
		k = (tree_keys.size() > 0) ? tree_keys[$urandom_range(0, tree_keys.size() - 1)] : rand_key();
		if (sel < 45) begin
			return k;
		end else if (sel < 60) begin
			return k + 1'b1;
		end else if (sel < 70) begin
			return k - 1'b1;
		end else if (sel < 78) begin
			return KEY_SENTINEL;
		end else if (sel < 84) begin
			return '0;
		end
		return rand_key();
	endfunction

	// Hold the request side idle until every search has been answered.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (open_lookups != 0) begin
			@(negedge clk);
		end
	endtask

	// Directed tree: root with one key and a sentinel, two middle nodes of a
	// sentinel each, a leaf holding the zero key, and a full leaf whose keys run
	// up to two below the sentinel.
	task automatic run_directed();
		key_vec_t root_key;
		req_word_t w;
		root_key = (rand_key() >> 1) | key_vec_t'(1);
		fill_slot(0, 0, 0, root_key, pick_count());
		fill_slot(0, 0, 1, KEY_SENTINEL, COUNT_MAX);
		fill_slot(1, 0, 0, KEY_SENTINEL, pick_count());
		fill_slot(1, 1, 0, KEY_SENTINEL, pick_count());
		fill_slot(2, 0, 0, '0, '0);
		fill_slot(2, 0, 1, KEY_SENTINEL, pick_count());
		for (int i = 0; i < NODE_KEYS; i++) begin
			fill_slot(2, NODE_KEYS, i, KEY_SENTINEL - key_vec_t'(NODE_KEYS + 1 - i), pick_count());
		end
		// A load on a level that does not exist must change nothing.
		w = rand_word();
		w.action = ACT_WRITE;
		w.level = 2'd3;
		w.slot = '0;
		{w.key_high, w.key_middle, w.key_low} = '0;
		send_word(w);
		// Lowest key, a root hit, the sentinel, the highest key, and one key
		// above every slot of the full leaf.
		search_key('0);
		search_key(root_key);
		search_key(KEY_SENTINEL);
		search_key(KEY_SENTINEL - key_vec_t'(2));
		search_key(KEY_SENTINEL - key_vec_t'(1));
		settle();
	endtask

	initial begin
		int sel;
		int pick;
		key_vec_t base;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();

		for (int p = 0; p < PHASES; p++) begin
			// Idling pattern of this phase.
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 57;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 57;
				end
				default: begin
					send_idle_pct = 13;
					stall_pct = 13;
				end
			endcase

			// Tree shape and key range: one phase with a full root, one with keys
			// near the top of the range.
			if (p == 5) begin
				inc_shift = 96;
				base = rand_key() | {3'b111, {(KEY_HIGH_W+KEY_MID_W+KEY_LOW_W-3){1'b0}}};
			end else begin
				inc_shift = 12;
				base = rand_key() >> $urandom_range(3, 40);
			end
			if (p == 2) begin
				plan_tree(NODE_KEYS, 1, 1, 0, base);
			end else begin
				plan_tree($urandom_range(0, 5), 3, 4, 4, base);
			end
			load_tree();

			// Searches, with count rewrites and stray writes between them.
			for (int n = 0; n < PROBES_PER_PHASE; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 80) begin
					search_key(pick_probe());
				end else if (sel < 90) begin
					pick = $urandom_range(0, layout.size() - 1);
					fill_slot(layout[pick].level, layout[pick].node, layout[pick].slot,
						layout[pick].key, pick_count());
				end else begin
					send_stray_write();
				end
			end
			settle();
		end

		// Drain and let the block run idle for a while before the verdict.
		req_ch.valid <= 1'b0;
		while (open_lookups != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && open_lookups == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/sbkl_pkg.sv
rtl/sbkl_if.sv
rtl/sbkl_store.sv
rtl/sbkl_cmp.sv
rtl/sbkl_ctrl.sv
rtl/static_btree_key_lookup_unit.sv
dv/sbkl_lookup_checker.sv
dv/static_btree_key_lookup_unit_test.sv
